// ===== hw/rtl/pwpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwpc_pkg
// shared types and constants of the pulse width and period capture block
// ----------------------------------------------------------------------------
package pwpc_pkg;

  localparam int COUNTER_BITS = 16;

  localparam int CLK_W       = 24;
  localparam int TICK_W      = 32;
  localparam int PERIOD_W    = TICK_W + 1;
  localparam int DVD_W       = 52;   // on ticks times one million
  localparam int DUTY_W      = 15;
  localparam int FREQ_W      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CLK_W-1:0] CLK_RESET  = 24'd1000000;
  localparam logic [19:0]      US_PER_S   = 20'd1000000;
  localparam logic [14:0]      PCT_Q8     = 15'd25600;

  typedef struct packed {
    logic              meas_valid;
    logic              wait_rising;
    logic [TICK_W-1:0] on_ticks;
    logic [TICK_W-1:0] off_ticks;
  } job_t;

endpackage

// ===== hw/rtl/pwpc_front.sv =====
// ----------------------------------------------------------------------------
// pwpc_front
// edge phase tracking and tick interval measurement
// ----------------------------------------------------------------------------
module pwpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic                operation,
  input  logic [15:0]         captured_value,
  output pwpc_pkg::job_t      job
);
  import pwpc_pkg::*;

  typedef enum logic [1:0] {
    PH_ARM  = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2
  } phase_t;

  localparam int                TW       = 16 + COUNTER_BITS + 1;
  localparam logic [TW-1:0]     MODULUS  = TW'(64'd1 << COUNTER_BITS);
  localparam logic [15:0]       CAP_MASK = 16'((64'd1 << COUNTER_BITS) - 64'd1);

  phase_t            phase_r, phase_nxt;
  logic [15:0]       rise_r, rise_nxt;
  logic [15:0]       fall_r, fall_nxt;
  logic [15:0]       ovf_r, ovf_nxt;
  logic [TICK_W-1:0] off_time_r, off_time_nxt;
  logic [15:0]       cap;
  logic [15:0]       ivl_start;
  logic [TW-1:0]     ivl_t;
  logic [TICK_W-1:0] ivl;

  assign cap = captured_value & CAP_MASK;

  // interval from start capture to this capture across counted overflows
  always_comb begin
    ivl_start = (phase_r == PH_RISE) ? fall_r : rise_r;
    ivl_t     = (TW'(ovf_r) << COUNTER_BITS) + TW'(cap);
    if (ivl_t < TW'(ivl_start)) begin
      ivl_t = ivl_t + MODULUS;
    end
    ivl_t = ivl_t - TW'(ivl_start);
    ivl   = (64'(ivl_t) > 64'hFFFF_FFFF) ? '1 : TICK_W'(ivl_t);
  end

  always_comb begin
    phase_nxt    = phase_r;
    rise_nxt     = rise_r;
    fall_nxt     = fall_r;
    ovf_nxt      = ovf_r;
    off_time_nxt = off_time_r;
    job          = '0;
    if (!operation) begin
      if (ovf_r != 16'hFFFF) begin
        ovf_nxt = ovf_r + 16'd1;
      end
    end else begin
      ovf_nxt = '0;
      unique case (phase_r)
        PH_RISE: begin
          rise_nxt     = cap;
          off_time_nxt = ivl;
          phase_nxt    = PH_FALL;
        end
        PH_FALL: begin
          fall_nxt       = cap;
          job.meas_valid = 1'b1;
          job.on_ticks   = ivl;
          job.off_ticks  = off_time_r;
          off_time_nxt   = '0;
          phase_nxt      = PH_ARM;
        end
        default: begin
          fall_nxt  = cap;
          phase_nxt = PH_RISE;
        end
      endcase
    end
    job.wait_rising = (phase_nxt == PH_RISE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ARM;
      rise_r     <= '0;
      fall_r     <= '0;
      ovf_r      <= '0;
      off_time_r <= '0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      rise_r     <= rise_nxt;
      fall_r     <= fall_nxt;
      ovf_r      <= ovf_nxt;
      off_time_r <= off_time_nxt;
    end
  end

endmodule

// ===== hw/rtl/pwpc_queue.sv =====
// ----------------------------------------------------------------------------
// pwpc_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module pwpc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  pwpc_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd,
  output pwpc_pkg::job_t rd_job,
  output logic           empty
);
  import pwpc_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full   = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) wptr_r <= wptr_r + 1'b1;
      if (rd) rptr_r <= rptr_r + 1'b1;
      if (wr && !rd)      cnt_r <= cnt_r + 1'b1;
      else if (rd && !wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/pwpc_back.sv =====
// ----------------------------------------------------------------------------
// pwpc_back
// scaling of a measurement: products and a shared bit-serial divider
// ----------------------------------------------------------------------------
module pwpc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pwpc_pkg::CLK_W-1:0]  clk_hz,
  input  logic                        q_empty,
  input  pwpc_pkg::job_t              q_job,
  output logic                        q_rd,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_measurement_valid,
  output logic                        out_wait_rising,
  output logic [31:0]                 out_on_ticks,
  output logic [31:0]                 out_off_ticks,
  output logic [31:0]                 out_on_time_us,
  output logic [14:0]                 out_duty_percent_q8,
  output logic [15:0]                 out_frequency_hz
);
  import pwpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_US, S_MUL_DUTY, S_LOAD_FREQ, S_DIV
  } state_t;

  typedef enum logic [1:0] {
    D_US, D_DUTY, D_FREQ
  } dsel_t;

  localparam int REM_W = PERIOD_W + 1;
  localparam int CNT_W = $clog2(DVD_W);

  state_t              state_r;
  dsel_t               dsel_r;
  logic                oval_r;
  logic [TICK_W-1:0]   on_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] dvs_r;
  logic [DVD_W-1:0]    dvd_r;
  logic [DVD_W-1:0]    quo_r;
  logic [REM_W-1:0]    rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [REM_W-1:0]    rem_sh;
  logic                qbit;
  logic [DVD_W-1:0]    quo_nxt;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
    qbit    = (rem_sh >= REM_W'(dvs_r));
    quo_nxt = {quo_r[DVD_W-2:0], qbit};
  end

  assign q_rd      = (state_r == S_IDLE) && !q_empty && !oval_r;
  assign out_empty = !oval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
      dsel_r  <= D_US;
      cnt_r   <= '0;
    end else begin
      if (out_pop && oval_r) oval_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_rd) begin
            on_r                  <= q_job.on_ticks;
            period_r              <= PERIOD_W'(q_job.on_ticks) + PERIOD_W'(q_job.off_ticks);
            out_measurement_valid <= q_job.meas_valid;
            out_wait_rising       <= q_job.wait_rising;
            out_on_ticks          <= q_job.on_ticks;
            out_off_ticks         <= q_job.off_ticks;
            out_on_time_us        <= '0;
            out_duty_percent_q8   <= '0;
            out_frequency_hz      <= '0;
            if (q_job.meas_valid) begin
              state_r <= S_MUL_US;
            end else begin
              oval_r <= 1'b1;
            end
          end
        end
        S_MUL_US: begin
          dvd_r   <= DVD_W'(on_r) * DVD_W'(US_PER_S);
          dvs_r   <= PERIOD_W'(clk_hz);
          dsel_r  <= D_US;
          state_r <= S_DIV;
        end
        S_MUL_DUTY: begin
          dvd_r   <= DVD_W'(on_r) * DVD_W'(PCT_Q8);
          dvs_r   <= period_r;
          dsel_r  <= D_DUTY;
          state_r <= S_DIV;
        end
        S_LOAD_FREQ: begin
          dvd_r   <= DVD_W'(clk_hz);
          dvs_r   <= period_r;
          dsel_r  <= D_FREQ;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= qbit ? (rem_sh - REM_W'(dvs_r)) : rem_sh;
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
          quo_r <= quo_nxt;
          if (cnt_r == CNT_W'(DVD_W - 1)) begin
            cnt_r <= '0;
            unique case (dsel_r)
              D_US: begin
                // zero on time is zero, division by a zero clock saturates
                if (on_r == '0)                out_on_time_us <= '0;
                else if (quo_nxt[DVD_W-1:32] != '0) out_on_time_us <= '1;
                else                           out_on_time_us <= quo_nxt[31:0];
                state_r <= S_MUL_DUTY;
              end
              D_DUTY: begin
                out_duty_percent_q8 <= (period_r == '0) ? '0 : quo_nxt[DUTY_W-1:0];
                state_r <= S_LOAD_FREQ;
              end
              default: begin
                out_frequency_hz <= (quo_nxt[DVD_W-1:FREQ_W] != '0) ? '1
                                                                    : quo_nxt[FREQ_W-1:0];
                oval_r  <= 1'b1;
                state_r <= S_IDLE;
              end
            endcase
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r != S_DIV) begin
        rem_r <= '0;
        quo_r <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/pulse_width_period_capture.sv =====
// ----------------------------------------------------------------------------
// pulse_width_period_capture
// pwm on time, off time, duty and frequency from timer capture transactions
// ----------------------------------------------------------------------------
// Each input transaction is a counter overflow tick or an edge capture. The
// first falling edge arms, the next rising edge gives the off time and the
// following falling edge closes the measurement with on time, on time in
// microseconds, duty in percent (q8) and frequency. Every input transaction
// gives exactly one result transaction, which also reports the polarity of
// the next edge to capture. The front side takes one transaction per cycle
// into a four entry queue while it is not full. A result without a
// measurement passes through the queue and is registered by the back, which
// reads its next job only once the last result is popped. A completed
// measurement is ready after three 52-step runs of the one shared bit-serial
// divider, each after a load state. The user must write timer_clock_hz
// through cfg_* only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module pulse_width_period_capture (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  // input transactions
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_operation,
  input  logic [15:0] in_captured_value,
  // result transactions
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_measurement_valid,
  output logic        out_wait_rising,
  output logic [31:0] out_on_ticks,
  output logic [31:0] out_off_ticks,
  output logic [31:0] out_on_time_us,
  output logic [14:0] out_duty_percent_q8,
  output logic [15:0] out_frequency_hz
);
  import pwpc_pkg::*;

  logic [CLK_W-1:0] clk_hz_r;
  logic             take;
  job_t             front_job;
  job_t             q_job;
  logic             q_empty;
  logic             q_rd;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_valid) begin
      clk_hz_r <= cfg_data;
    end
  end

  // input transaction accepted
  assign take = in_push && !in_full;

  pwpc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .operation      (in_operation),
    .captured_value (in_captured_value),
    .job            (front_job)
  );

  pwpc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (take),
    .wr_job (front_job),
    .full   (in_full),
    .rd     (q_rd),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  pwpc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .clk_hz                (clk_hz_r),
    .q_empty               (q_empty),
    .q_job                 (q_job),
    .q_rd                  (q_rd),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_measurement_valid (out_measurement_valid),
    .out_wait_rising       (out_wait_rising),
    .out_on_ticks          (out_on_ticks),
    .out_off_ticks         (out_off_ticks),
    .out_on_time_us        (out_on_time_us),
    .out_duty_percent_q8   (out_duty_percent_q8),
    .out_frequency_hz      (out_frequency_hz)
  );

endmodule
